/* rtl/dtt_pkg.sv */
// ----------------------------------------------------------------------------
// dtt_pkg: shared types and constants of the deadline timer table
// Field widths, command and result codes, and the request record that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package dtt_pkg;

   localparam int TableDepth = 16;
   localparam int TimeBits   = 32;
   localparam int CbIdBits   = 16;
   localparam int SeqBits    = 32;
   localparam int IdxBits    = $clog2(TableDepth);
   localparam int MaxResults = 16;

   typedef enum logic [1:0] {
      FUNC_SCHEDULE   = 2'd0,
      FUNC_CANCEL     = 2'd1,
      FUNC_RESCHEDULE = 2'd2,
      FUNC_PULSE      = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      KIND_ISSUED      = 3'd0,
      KIND_CANCELLED   = 3'd1,
      KIND_CANCEL_MISS = 3'd2,
      KIND_FIRED       = 3'd3,
      KIND_NONE_DUE    = 3'd4,
      KIND_FULL        = 3'd5,
      KIND_RESCHED_MISS = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FIRE
   } state_type;

   // request as classified by the front end
   typedef struct packed {
      func_type              func;
      logic [TimeBits-1:0]   deadline;   // saturated now+delay, or 0
      logic                  zero_delay;
      logic [TimeBits-1:0]   limit;      // pulse bound
      logic [CbIdBits-1:0]   cb_id;
      logic [TimeBits-1:0]   ticket_time;
      logic [SeqBits-1:0]    ticket_seq;
   } req_type;

endpackage

/* rtl/dtt_front.sv */
// ----------------------------------------------------------------------------
// dtt_front: request intake and classification
// Computes the saturated deadline and pulse limit, then pushes the
// request into a two-entry queue read by the back end.
// ----------------------------------------------------------------------------
module dtt_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_func,
   input  logic [dtt_pkg::TimeBits-1:0] req_delay,
   input  logic [dtt_pkg::TimeBits-1:0] req_current_time,
   input  logic [dtt_pkg::CbIdBits-1:0] req_cb_id,
   input  logic [dtt_pkg::TimeBits-1:0] req_ticket_time,
   input  logic [dtt_pkg::SeqBits-1:0]  req_ticket_seq,
   input  logic                        req_immediate,
   output logic                        q_valid,
   input  logic                        q_pop,
   output dtt_pkg::req_type            q_data
);
   import dtt_pkg::*;

   req_type           slot_ff [2];
   logic              slot_in_valid;
   logic [1:0]        count_ff, count_in;
   logic              rd_ff, rd_in, wr_ff, wr_in;
   req_type           item;
   logic [TimeBits:0] sum;
   logic              push;

   assign sum = {1'b0, req_current_time} + {1'b0, req_delay};

   always_comb begin
      item.func        = func_type'(req_func);
      item.zero_delay  = (req_delay == '0);
      item.deadline    = item.zero_delay ? '0 :
                         (sum[TimeBits] ? {TimeBits{1'b1}} : sum[TimeBits-1:0]);
      item.limit       = req_immediate ? '0 : req_current_time;
      item.cb_id       = req_cb_id;
      item.ticket_time = req_ticket_time;
      item.ticket_seq  = req_ticket_seq;
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = slot_ff[rd_ff];
   assign slot_in_valid = push;

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
      rd_in    = q_pop ? ~rd_ff : rd_ff;
      wr_in    = push ? ~wr_ff : wr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
      if (slot_in_valid) slot_ff[wr_ff] <= item;
   end

endmodule

/* rtl/dtt_back.sv */
// ----------------------------------------------------------------------------
// dtt_back: timer table and command execution
// Holds the entries, matches tickets, finds free slots and walks due
// entries in deadline-then-sequence order for a pulse.
// ----------------------------------------------------------------------------
module dtt_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  dtt_pkg::req_type            q_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_kind,
   output logic [dtt_pkg::TimeBits-1:0] rsp_out_time,
   output logic [dtt_pkg::SeqBits-1:0]  rsp_out_seq,
   output logic [dtt_pkg::CbIdBits-1:0] rsp_out_cb_id,
   output logic                        rsp_immediate_request,
   output logic                        rsp_last
);
   import dtt_pkg::*;

   logic [TableDepth-1:0] valid_ff, valid_in;
   logic [TimeBits-1:0]   dl_ff  [TableDepth];
   logic [SeqBits-1:0]    seq_ff [TableDepth];
   logic [CbIdBits-1:0]   cb_ff  [TableDepth];
   logic [SeqBits-1:0]    ctr_ff, ctr_in;
   state_type             state_ff, state_in;
   logic [$clog2(MaxResults+1)-1:0] nfire_ff, nfire_in;

   // output register
   logic                  ov_ff, ov_in;
   logic [2:0]            ok_ff, ok_in;
   logic [TimeBits-1:0]   ot_ff, ot_in;
   logic [SeqBits-1:0]    os_ff, os_in;
   logic [CbIdBits-1:0]   oc_ff, oc_in;
   logic                  oi_ff, oi_in;
   logic                  ol_ff, ol_in;

   // best-entry register from the search pass
   logic                  bf_ff, bf_in;
   logic [IdxBits-1:0]    bi_ff, bi_in;

   logic                  wr_en;
   logic [IdxBits-1:0]    wr_idx;
   logic [TimeBits-1:0]   wr_dl;
   logic [SeqBits-1:0]    wr_seq;
   logic [CbIdBits-1:0]   wr_cb;

   logic [SeqBits-1:0]    new_seq;
   logic                  tk_hit, nw_hit, fr_hit;
   logic [IdxBits-1:0]    tk_idx, nw_idx, fr_idx;
   logic                  mn_hit;
   logic [IdxBits-1:0]    mn_idx;
   logic [TableDepth-1:0] vmask;
   logic                  out_free;

   // minimum tree nodes
   logic                  mt_v [TableDepth];
   logic [IdxBits-1:0]    mt_i [TableDepth];
   logic [TimeBits-1:0]   mt_d [TableDepth];
   logic [SeqBits-1:0]    mt_s [TableDepth];
   logic                  mt_b;

   assign out_free = !ov_ff || rsp_ready;
   assign new_seq  = (ctr_ff + 1'b1 == '0) ? {{(SeqBits-1){1'b0}}, 1'b1} : ctr_ff + 1'b1;

   // match and free-slot search
   always_comb begin
      tk_hit = 1'b0; tk_idx = '0;
      nw_hit = 1'b0; nw_idx = '0;
      fr_hit = 1'b0; fr_idx = '0;
      for (int i = TableDepth - 1; i >= 0; i--) begin
         if (valid_ff[i] && dl_ff[i] == q_data.ticket_time && seq_ff[i] == q_data.ticket_seq) begin
            tk_hit = 1'b1; tk_idx = IdxBits'(i);
         end
         if (!valid_ff[i]) begin
            fr_hit = 1'b1; fr_idx = IdxBits'(i);
         end
      end
      // mask out the ticket being moved on reschedule
      vmask = valid_ff;
      if (q_data.func == FUNC_RESCHEDULE && tk_hit) vmask[tk_idx] = 1'b0;
      for (int i = TableDepth - 1; i >= 0; i--) begin
         if (vmask[i] && dl_ff[i] == q_data.deadline && seq_ff[i] == new_seq) begin
            nw_hit = 1'b1; nw_idx = IdxBits'(i);
         end
      end
      if (q_data.func == FUNC_RESCHEDULE && tk_hit && !fr_hit) begin
         fr_hit = 1'b1; fr_idx = tk_idx;
      end
      if (q_data.func == FUNC_RESCHEDULE && tk_hit && fr_hit && tk_idx < fr_idx) begin
         fr_idx = tk_idx;
      end
   end

   // minimum search over the table as a pairwise tree; ties keep the lower index
   always_comb begin
      mt_b = 1'b0;
      for (int i = 0; i < TableDepth; i++) begin
         mt_v[i] = valid_ff[i]; mt_i[i] = IdxBits'(i);
         mt_d[i] = dl_ff[i];    mt_s[i] = seq_ff[i];
      end
      for (int lv = 0; lv < IdxBits; lv++) begin
         for (int i = 0; i < (TableDepth >> (lv + 1)); i++) begin
            mt_b = mt_v[2*i+1] && (!mt_v[2*i] || mt_d[2*i+1] < mt_d[2*i] ||
                   (mt_d[2*i+1] == mt_d[2*i] && mt_s[2*i+1] < mt_s[2*i]));
            mt_v[i] = mt_v[2*i] || mt_v[2*i+1];
            mt_i[i] = mt_b ? mt_i[2*i+1] : mt_i[2*i];
            mt_d[i] = mt_b ? mt_d[2*i+1] : mt_d[2*i];
            mt_s[i] = mt_b ? mt_s[2*i+1] : mt_s[2*i];
         end
      end
      mn_hit = mt_v[0];
      mn_idx = mt_i[0];
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      ctr_in   = ctr_ff;
      nfire_in = nfire_ff;
      bf_in = bf_ff; bi_in = bi_ff;
      ov_in = ov_ff && !rsp_ready;
      ok_in = ok_ff; ot_in = ot_ff; os_in = os_ff;
      oc_in = oc_ff; oi_in = oi_ff; ol_in = ol_ff;
      q_pop = 1'b0;
      wr_en = 1'b0; wr_idx = '0; wr_dl = q_data.deadline; wr_seq = new_seq;
      wr_cb = q_data.cb_id;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               ov_in = 1'b1; ol_in = 1'b1; oi_in = 1'b0;
               ot_in = '0; os_in = '0; oc_in = '0;
               unique case (q_data.func)
                  FUNC_SCHEDULE, FUNC_RESCHEDULE: begin
                     if (q_data.func == FUNC_RESCHEDULE && !tk_hit) begin
                        ok_in = KIND_RESCHED_MISS;
                     end else begin
                        if (q_data.func == FUNC_RESCHEDULE) begin
                           valid_in[tk_idx] = 1'b0;
                           wr_cb = cb_ff[tk_idx];
                        end
                        if (nw_hit || fr_hit) begin
                           wr_en  = 1'b1;
                           wr_idx = nw_hit ? nw_idx : fr_idx;
                           valid_in[wr_idx] = 1'b1;
                           ctr_in = new_seq;
                           ok_in = KIND_ISSUED;
                           ot_in = q_data.deadline; os_in = new_seq; oc_in = wr_cb;
                           oi_in = q_data.zero_delay;
                        end else begin
                           ok_in = KIND_FULL;
                        end
                     end
                     q_pop = 1'b1;
                  end
                  FUNC_CANCEL: begin
                     if (tk_hit) begin
                        valid_in[tk_idx] = 1'b0;
                        ok_in = KIND_CANCELLED;
                        ot_in = q_data.ticket_time; os_in = q_data.ticket_seq;
                        oc_in = cb_ff[tk_idx];
                     end else begin
                        ok_in = KIND_CANCEL_MISS;
                     end
                     q_pop = 1'b1;
                  end
                  FUNC_PULSE: begin
                     ov_in = ov_ff && !rsp_ready;
                     nfire_in = '0;
                     state_in = ST_SEARCH;
                  end
                  default: ;
               endcase
            end
         end
         ST_SEARCH: begin
            bf_in = mn_hit && dl_ff[mn_idx] <= q_data.limit &&
                    nfire_ff != ($clog2(MaxResults+1))'(MaxResults);
            bi_in = mn_idx;
            state_in = ST_FIRE;
         end
         ST_FIRE: begin
            if (out_free) begin
               if (bf_ff) begin
                  // hold one fired result back until we know if it is final
                  valid_in[bi_ff] = 1'b0;
                  ov_in = 1'b1; ok_in = KIND_FIRED;
                  ot_in = dl_ff[bi_ff]; os_in = seq_ff[bi_ff]; oc_in = cb_ff[bi_ff];
                  oi_in = 1'b0; ol_in = 1'b0;
                  nfire_in = nfire_ff + 1'b1;
                  state_in = ST_SEARCH;
               end else if (nfire_ff == '0) begin
                  ov_in = 1'b1; ok_in = KIND_NONE_DUE; ot_in = '0; os_in = '0;
                  oc_in = '0; oi_in = 1'b0; ol_in = 1'b1;
                  q_pop = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  q_pop = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fired results look ahead: last is decided at search time below
   logic pend_ff, pend_in;
   logic [2:0] pk_ff; logic [TimeBits-1:0] pt_ff; logic [SeqBits-1:0] ps_ff;
   logic [CbIdBits-1:0] pc_ff; logic pi_ff;
   logic stage_load, stage_close;

   // a fired result sits in the pending stage; next search says whether it is last
   assign stage_load  = (state_ff == ST_FIRE) && out_free && bf_ff;
   assign stage_close = (state_ff == ST_FIRE) && out_free && !bf_ff && nfire_ff != '0;

   always_comb begin
      pend_in = pend_ff;
      if (stage_load || stage_close) pend_in = stage_load;
      if (ov_in && !stage_load && !stage_close && state_ff == ST_IDLE) pend_in = 1'b0;
   end

   logic emit_v; logic [2:0] emit_k; logic [TimeBits-1:0] emit_t;
   logic [SeqBits-1:0] emit_s; logic [CbIdBits-1:0] emit_c; logic emit_i, emit_l;

   always_comb begin
      emit_v = ov_in; emit_k = ok_in; emit_t = ot_in; emit_s = os_in;
      emit_c = oc_in; emit_i = oi_in; emit_l = ol_in;
      if (stage_load) begin
         emit_v = pend_ff || (ov_ff && !rsp_ready);
         emit_k = pend_ff ? pk_ff : ok_ff; emit_t = pend_ff ? pt_ff : ot_ff;
         emit_s = pend_ff ? ps_ff : os_ff; emit_c = pend_ff ? pc_ff : oc_ff;
         emit_i = pend_ff ? pi_ff : oi_ff; emit_l = pend_ff ? 1'b0 : ol_ff;
      end else if (stage_close) begin
         emit_v = 1'b1; emit_k = pk_ff; emit_t = pt_ff; emit_s = ps_ff;
         emit_c = pc_ff; emit_i = pi_ff; emit_l = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         ctr_ff   <= '0;
         ov_ff    <= 1'b0;
         pend_ff  <= 1'b0;
         nfire_ff <= '0;
         bf_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         ctr_ff   <= ctr_in;
         ov_ff    <= emit_v;
         pend_ff  <= pend_in;
         nfire_ff <= nfire_in;
         bf_ff    <= bf_in;
      end
      bi_ff <= bi_in;
      ok_ff <= emit_k; ot_ff <= emit_t; os_ff <= emit_s;
      oc_ff <= emit_c; oi_ff <= emit_i; ol_ff <= emit_l;
      if (stage_load) begin
         pk_ff <= ok_in; pt_ff <= ot_in; ps_ff <= os_in;
         pc_ff <= oc_in; pi_ff <= oi_in;
      end
      if (wr_en) begin
         dl_ff[wr_idx]  <= wr_dl;
         seq_ff[wr_idx] <= wr_seq;
         cb_ff[wr_idx]  <= wr_cb;
      end
   end

   assign rsp_valid             = ov_ff;
   assign rsp_kind              = ok_ff;
   assign rsp_out_time          = ot_ff;
   assign rsp_out_seq           = os_ff;
   assign rsp_out_cb_id         = oc_ff;
   assign rsp_immediate_request = oi_ff;
   assign rsp_last              = ol_ff;

endmodule

/* rtl/deadline_timer_table_unit.sv */
// ----------------------------------------------------------------------------
// deadline_timer_table_unit: bounded timer table ordered by deadline
// Top level joining the request front end and the table back end.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_ready with a command in req_func.
//   Schedule, cancel and reschedule give one response each; a pulse
//   gives one fired response per due timer, in deadline then sequence
//   order (at most 16), or a single none-due response. rsp_last marks
//   the final response of a request.
//   The front end takes a request whenever its two-entry queue has room,
//   so a request may be accepted while a response still waits.
//   Schedule, cancel and reschedule are executed by the back end in its idle
//   state, and the response is registered. A pulse leaves idle, then for
//   each fired timer does a minimum search over the 16 entries and an
//   issue step, and then closes; a pulse with no due timer gives its
//   none-due response after a single search. A request queued behind
//   another waits until that one is done.
//   Reset empties the table and clears the sequence counter.
//   A stalled rsp_ready holds the response register and the back end
//   waits; the queue then fills and req_ready drops.
// ----------------------------------------------------------------------------
module deadline_timer_table_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_func,
   input  logic [dtt_pkg::TimeBits-1:0]  req_delay,
   input  logic [dtt_pkg::TimeBits-1:0]  req_current_time,
   input  logic [dtt_pkg::CbIdBits-1:0]  req_cb_id,
   input  logic [dtt_pkg::TimeBits-1:0]  req_ticket_time,
   input  logic [dtt_pkg::SeqBits-1:0]   req_ticket_seq,
   input  logic                         req_immediate,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_kind,
   output logic [dtt_pkg::TimeBits-1:0]  rsp_out_time,
   output logic [dtt_pkg::SeqBits-1:0]   rsp_out_seq,
   output logic [dtt_pkg::CbIdBits-1:0]  rsp_out_cb_id,
   output logic                         rsp_immediate_request,
   output logic                         rsp_last
);
   import dtt_pkg::*;

   logic    q_valid, q_pop;
   req_type q_data;

   dtt_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_delay,
      .req_current_time, .req_cb_id, .req_ticket_time, .req_ticket_seq,
      .req_immediate, .q_valid, .q_pop, .q_data
   );

   dtt_back u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data, .rsp_valid, .rsp_ready,
      .rsp_kind, .rsp_out_time, .rsp_out_seq, .rsp_out_cb_id,
      .rsp_immediate_request, .rsp_last
   );

   a_imm_only_issued: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_immediate_request |-> rsp_kind == KIND_ISSUED)
      else $error("immediate_request outside issued");

   a_fired_not_alone_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_FIRED |-> rsp_last)
      else $error("non-fired response without last");

   a_pop_needs_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

endmodule
